FILE: hdl/mr2u_pkg.sv
// mr2u_pkg: shared types, constants and the high-half code point table
// for the legacy charset to utf-8 transcoder; no dependencies
`timescale 1ns / 1ps

package mr2u_pkg;

  // register map and reset values
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_CAPACITY = 3'd0;
  localparam logic [15:0] CAPACITY_RESET   = 16'd4096;

  // queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH = 4;

  // utf-8 lead and continuation markers
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  // sequence length codes
  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE  = 2'd1;
  localparam logic [1:0] NEED_TWO  = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // one queued job: the data bytes of one source byte plus an optional terminator
  typedef struct packed {
    logic [1:0]      n_data;
    logic [2:0][7:0] data;
    logic            eot;
    logic [15:0]     count;
    logic            trunc;
  } mr2u_job_t;

  // code points for bytes 0x80 to 0xff
  localparam logic [15:0] HI_MAP [128] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

endpackage

FILE: hdl/mr2u_if.sv
// mr2u_in_if / mr2u_out_if: valid/ready channels for source words and result words
// depends on nothing
`timescale 1ns / 1ps

interface mr2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] mac_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, mac_byte, has_byte, end_of_text, input ready);
  modport sink   (input valid, mac_byte, has_byte, end_of_text, output ready);
endinterface

interface mr2u_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_terminator;
  logic [15:0] written_count;
  logic        was_truncated;
  logic        last;

  modport source (output valid, out_byte, is_terminator, written_count, was_truncated, last,
                  input ready);
  modport sink   (input valid, out_byte, is_terminator, written_count, was_truncated, last,
                  output ready);
endinterface

FILE: hdl/mr2u_front.sv
// mr2u_front: accepts source words, maps them to utf-8 and checks room
// depends on mr2u_pkg and mr2u_in_if
`timescale 1ns / 1ps

module mr2u_front (
  input  logic                  clk,
  input  logic                  rst_n,
  mr2u_in_if.sink               in_ch,
  input  logic [15:0]           capacity,
  input  logic                  q_full,
  output logic                  q_push,
  output mr2u_pkg::mr2u_job_t   q_job
);
  import mr2u_pkg::*;

  logic [15:0] out_count_r, out_count_nxt;
  logic        halted_r, halted_nxt;
  logic [15:0] cp;
  logic [1:0]  need;
  logic        fits;
  logic        do_byte;
  logic        emit;
  logic [15:0] count_upd;
  logic        halt_upd;
  logic        accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // code point and sequence length
  always_comb begin
    if (in_ch.mac_byte[7]) begin
      cp = HI_MAP[in_ch.mac_byte[6:0]];
    end else begin
      cp = {8'h00, in_ch.mac_byte};
    end
    if (!in_ch.mac_byte[7]) begin
      need = NEED_ONE;
    end else if (cp < 16'h0800) begin
      need = NEED_TWO;
    end else begin
      need = NEED_THREE;
    end
  end

  // room check: count + need + nul must not exceed the capacity
  assign fits = ({1'b0, out_count_r} + 17'(need) + 17'd1) <= {1'b0, capacity};

  assign do_byte   = in_ch.has_byte && !halted_r;
  assign emit      = do_byte && fits;
  assign count_upd = emit ? out_count_r + 16'(need) : out_count_r;
  assign halt_upd  = halted_r || (do_byte && !fits);

  // job for the back part
  always_comb begin
    q_job.n_data = emit ? need : NEED_NONE;
    q_job.eot    = in_ch.end_of_text;
    q_job.count  = count_upd;
    q_job.trunc  = halt_upd;
    q_job.data   = '0;
    case (need)
      NEED_ONE: begin
        q_job.data[0] = cp[7:0];
      end
      NEED_TWO: begin
        q_job.data[0] = {LEAD2_TAG, cp[10:6]};
        q_job.data[1] = {CONT_TAG, cp[5:0]};
      end
      NEED_THREE: begin
        q_job.data[0] = {LEAD3_TAG, cp[15:12]};
        q_job.data[1] = {CONT_TAG, cp[11:6]};
        q_job.data[2] = {CONT_TAG, cp[5:0]};
      end
      default: begin
        q_job.data = '0;
      end
    endcase
  end

  assign q_push = accept && (emit || in_ch.end_of_text);

  // running count and halt flag
  always_comb begin
    out_count_nxt = out_count_r;
    halted_nxt    = halted_r;
    if (accept) begin
      if (in_ch.end_of_text) begin
        out_count_nxt = '0;
        halted_nxt    = 1'b0;
      end else begin
        out_count_nxt = count_upd;
        halted_nxt    = halt_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_count_r <= '0;
      halted_r    <= 1'b0;
    end else begin
      out_count_r <= out_count_nxt;
      halted_r    <= halted_nxt;
    end
  end

endmodule

FILE: hdl/mr2u_fifo.sv
// mr2u_fifo: short job queue between the front and back parts
// depends on mr2u_pkg
`timescale 1ns / 1ps

module mr2u_fifo #(
  parameter int unsigned DEPTH = mr2u_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mr2u_pkg::mr2u_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output mr2u_pkg::mr2u_job_t pop_job
);
  import mr2u_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mr2u_job_t       store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full      = cnt_r == CW'(DEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_job   = store_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: hdl/mr2u_back.sv
// mr2u_back: takes jobs from the queue and sends one result word per cycle
// while out_ch is ready; depends on mr2u_pkg and mr2u_out_if
`timescale 1ns / 1ps

module mr2u_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  mr2u_pkg::mr2u_job_t q_job,
  output logic                q_pop,
  mr2u_out_if.source          out_ch
);
  import mr2u_pkg::*;

  mr2u_job_t   job_r;
  logic        job_valid_r, job_valid_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [2:0]  n_res;
  logic        res_last;
  logic        adv;
  logic        fin;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r;
  logic        term_r;
  logic [15:0] count_r;
  logic        trunc_r;
  logic        last_r;

  // result position within the current job
  assign n_res    = {1'b0, job_r.n_data} + {2'b00, job_r.eot};
  assign res_last = (3'(pos_r) + 3'd1) == n_res;
  assign adv      = job_valid_r && (!out_valid_r || out_ch.ready);
  assign fin      = adv && res_last;
  assign q_pop    = q_valid && (!job_valid_r || fin);

  always_comb begin
    job_valid_nxt = job_valid_r;
    pos_nxt       = pos_r;
    if (q_pop) begin
      job_valid_nxt = 1'b1;
      pos_nxt       = '0;
    end else if (fin) begin
      job_valid_nxt = 1'b0;
      pos_nxt       = '0;
    end else if (adv) begin
      pos_nxt = pos_r + 1'b1;
    end
    out_valid_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // job holding register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

  // output register: data byte or terminator
  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= res_last;
      if (pos_r < job_r.n_data) begin
        byte_r  <= job_r.data[pos_r];
        term_r  <= 1'b0;
        count_r <= '0;
        trunc_r <= 1'b0;
      end else begin
        byte_r  <= '0;
        term_r  <= 1'b1;
        count_r <= job_r.count;
        trunc_r <= job_r.trunc;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.is_terminator = term_r;
  assign out_ch.written_count = count_r;
  assign out_ch.was_truncated = trunc_r;
  assign out_ch.last          = last_r;

endmodule

FILE: hdl/legacy_charset_to_utf8_top.sv
// legacy_charset_to_utf8_top: mac roman to utf-8 transcoder, top level
// depends on mr2u_pkg, mr2u_if, mr2u_front, mr2u_fifo and mr2u_back
//
// in_ch carries one source word per handshake: a byte, a has-byte flag and
// an end-of-text flag. out_ch returns the utf-8 bytes of each byte in order,
// one word per cycle while the receiver is ready, then a nul terminator
// word when end-of-text is set; last marks the final word caused by an
// input word. An input word yields 0 to 4 output words; the output port,
// one word a cycle while the receiver is ready, sets the sustained rate.
// The first result word passes through the job queue, the job holding
// register and the output register. in_ch stays ready while the job queue
// has room, so input words keep flowing while results wait to be taken.
// The capacity register (byte address 0) sets the buffer size in bytes
// including the nul; a byte that would not fit halts the text until the
// next end-of-text. Write it only while the block is idle.
// Reset (rst_n low, synchronous) empties the queue and output stage, clears
// the count and halt flag and sets the capacity to 4096. If the receiver
// stalls, the output word holds and the queue fills, then in_ch drops ready.
`timescale 1ns / 1ps

module legacy_charset_to_utf8_top #(
  parameter int unsigned QUEUE_DEPTH = mr2u_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mr2u_in_if.sink                             in_ch,
  mr2u_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mr2u_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mr2u_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mr2u_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import mr2u_pkg::*;

  logic [15:0] capacity_r;
  logic        cfg_wr;
  logic        cap_sel;
  logic        q_push, q_full, q_pop, q_valid;
  mr2u_job_t   push_job, pop_job;

  // configuration register
  assign pready  = 1'b1;
  assign cap_sel = paddr[CFG_ADDR_W-1:2] == REG_OUT_CAPACITY[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && cap_sel;
  assign prdata  = cap_sel ? {{(CFG_DATA_W-16){1'b0}}, capacity_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_wr) begin
      capacity_r <= pwdata[15:0];
    end
  end

  // front: accept, map, room check
  mr2u_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .capacity (capacity_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // job queue
  mr2u_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (pop_job)
  );

  // back: result sequencing and output register
  mr2u_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
